>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define CSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csf assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define CSF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csf assertion failed");

`endif

>>> rtl/csf_pkg.sv
// Types, constants and helper functions of the checker sweep fade pixel core.
package csf_pkg;

    localparam int MAX_MATRICES = 3;
    localparam logic [1:0] MAX_COUNT = (MAX_MATRICES > 3) ? 2'd3 : 2'(MAX_MATRICES);

    localparam int TIME_W     = 16;
    localparam int INTERVAL_W = 14;
    localparam int START_W    = 17;
    localparam int HALF_W     = 15;
    localparam int LEVEL_W    = 8;
    localparam int NUM_W      = HALF_W + LEVEL_W;
    localparam int COLOR_W    = 16;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = LEVEL_W / DIV_STAGES;
    localparam int RECIP_W    = 17;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0]  COUNT_RESET    = 2'd1;
    localparam logic [15:0] DURATION_RESET = 16'd2000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MATRIX_COUNT = 1'b0,
        CFG_DURATION_MS  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0] elapsed_ms;
        logic [1:0]        matrix_index;
        logic [2:0]        pixel_x;
        logic [2:0]        pixel_y;
    } pix_t;

    typedef struct packed {
        logic [TIME_W-1:0]     elapsed_ms;
        logic [INTERVAL_W-1:0] interval;
        logic [3:0]            colsel;
        logic                  lit;
    } cell_t;

    typedef struct packed {
        logic [TIME_W-1:0]     elapsed_ms;
        logic [START_W-1:0]    start;
        logic [INTERVAL_W-1:0] interval;
        logic                  lit;
    } geom_t;

    typedef struct packed {
        logic [NUM_W-1:0]   rem;
        logic [HALF_W-1:0]  half;
        logic [LEVEL_W-1:0] quo;
        logic               dark;
    } div_t;

    typedef struct packed {
        logic [RECIP_W-1:0] mult;
        logic [4:0]         shift;
    } recip_t;

    // Exact reciprocal of (4 * count + 3) for any 16-bit dividend.
    function automatic recip_t interval_recip(input logic [1:0] count);
        recip_t r;
        case (count)
            2'd2:    r = '{mult: 17'd95326, shift: 5'd20};
            2'd3:    r = '{mult: 17'd69906, shift: 5'd20};
            default: r = '{mult: 17'd74899, shift: 5'd19};
        endcase
        return r;
    endfunction

    function automatic logic [COLOR_W-1:0] gray565(input logic [LEVEL_W-1:0] v);
        return {v[7:3], v[7:2], v[7:3]};
    endfunction

endpackage

>>> rtl/csf_geom.sv
// Checker cell decode, group interval and column start time (two stages).
module csf_geom import csf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       matrix_count,
    input  logic [15:0]      duration_ms,
    input  logic             in_valid,
    output logic             in_ready,
    input  pix_t             in_pix,
    output logic             out_valid,
    input  logic             out_ready,
    output geom_t            out_geom
);

    logic  s1_valid_reg;
    logic  s2_valid_reg;
    cell_t s1_reg;
    cell_t s1_next;
    geom_t s2_reg;
    geom_t s2_next;
    logic  s1_en;
    logic  s2_en;

    assign s2_en    = !s2_valid_reg || out_ready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    always_comb
    begin
        logic [1:0]            count;
        logic [3:0]            groups;
        logic [3:0]            cx;
        recip_t                rc;
        logic [TIME_W+RECIP_W-1:0] prod;
        count = matrix_count;
        if (count == 2'd0)
            count = 2'd1;
        if (count > MAX_COUNT)
            count = MAX_COUNT;
        groups = {count, 2'b00};
        cx     = {in_pix.matrix_index, in_pix.pixel_x[2:1]};
        rc     = interval_recip(count);
        prod   = (TIME_W+RECIP_W)'(duration_ms) * (TIME_W+RECIP_W)'(rc.mult);
        s1_next.elapsed_ms = in_pix.elapsed_ms;
        s1_next.interval   = INTERVAL_W'(prod >> rc.shift);
        s1_next.colsel     = groups - 4'd1 - cx;
        // even parity of checker column plus checker row, flag rows only
        s1_next.lit = (in_pix.matrix_index < count) && in_pix.pixel_y[2]
                      && !(in_pix.pixel_x[1] ^ in_pix.pixel_y[1]);
    end

    always_comb
    begin
        s2_next.elapsed_ms = s1_reg.elapsed_ms;
        s2_next.interval   = s1_reg.interval;
        s2_next.lit        = s1_reg.lit;
        s2_next.start      = START_W'(s1_reg.colsel) * START_W'(s1_reg.interval);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
            s1_reg <= s1_next;
        if (s2_en)
            s2_reg <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_geom  = s2_reg;

endmodule

>>> rtl/csf_ramp.sv
// Triangle position within the fade and dividend for the level division.
module csf_ramp import csf_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  geom_t in_geom,
    output logic  out_valid,
    input  logic  out_ready,
    output div_t  out_div
);

    logic valid_reg;
    div_t div_reg;
    div_t div_next;
    logic en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        logic              early;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] fade;
        logic [HALF_W-1:0] half;
        logic              over;
        logic [HALF_W-1:0] tp;
        early = {1'b0, in_geom.elapsed_ms} < in_geom.start;
        t     = in_geom.elapsed_ms - in_geom.start[TIME_W-1:0];
        fade  = {in_geom.interval, 2'b00};
        half  = {in_geom.interval, 1'b0};
        over  = t >= fade;
        // rising edge up to the peak, falling edge after it
        if (t <= {1'b0, half})
            tp = t[HALF_W-1:0];
        else
            tp = HALF_W'(fade - t);
        div_next.rem  = {tp, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, tp};
        div_next.half = half;
        div_next.quo  = '0;
        div_next.dark = !in_geom.lit || early || over || (in_geom.interval == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            div_reg <= div_next;
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;

endmodule

>>> rtl/csf_div.sv
// Pipelined restoring divider for the fade level, a few quotient bits per stage.
module csf_div import csf_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_div,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_div
);

    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] src_valid;
    div_t                  stg_reg  [DIV_STAGES];
    div_t                  stg_next [DIV_STAGES];
    logic [DIV_STAGES:0]   en;

    assign in_ready  = en[0];
    assign src_valid = {vld_reg[DIV_STAGES-2:0], in_valid};

    // A stage advances when it is empty or its successor advances.
    always_comb
    begin
        en[DIV_STAGES] = out_ready;
        for (int s = DIV_STAGES - 1; s >= 0; s--)
            en[s] = !vld_reg[s] || en[s+1];
    end

    always_comb
    begin
        div_t             w;
        logic [NUM_W-1:0] trial;
        int               b;
        w     = '0;
        trial = '0;
        b     = 0;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            w = (s == 0) ? in_div : stg_reg[(s == 0) ? 0 : s - 1];
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                b     = LEVEL_W - 1 - (s * DIV_STEPS + j);
                trial = NUM_W'(w.half) << b;
                if (w.rem >= trial)
                begin
                    w.rem = w.rem - trial;
                    w.quo[3'(b)] = 1'b1;
                end
            end
            stg_next[s] = w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                if (en[s])
                    vld_reg[s] <= src_valid[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (en[s])
                stg_reg[s] <= stg_next[s];
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_div   = stg_reg[DIV_STAGES-1];

endmodule

>>> rtl/checker_sweep_fade_pixel_core.sv
// Top level of the checker sweep fade pixel core.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tdata: elapsed_ms, matrix_index, pixel_x, pixel_y
//   m_*       out  m_tvalid/m_tready  m_tdata: color565
//   cfg_*     in   cfg_we             cfg_index, cfg_data (no read-back)
//
// One request enters per cycle while the output side is not stalled; its color
// becomes valid on m_tdata once the request has passed the register stages below.
// Nine register stages: input register, cell decode with the interval reciprocal
// multiply, start multiply, fade position, four divider stages of two quotient
// bits each, and the color output register.
// Reset clears every valid bit and loads matrix_count = 1, duration_ms = 2000.
// Each stage holds while its successor is full and stalled, so bubbles are
// squeezed out and s_tready stays high while the pipeline has a free slot.
module checker_sweep_fade_pixel_core import csf_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // pixel requests
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // [15:0] elapsed_ms, [17:16] matrix_index,
                                              // [20:18] pixel_x, [23:21] pixel_y
    // pixel colors
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata    // [15:0] color565
);

    logic [1:0]  matrix_count_reg;
    logic [15:0] duration_ms_reg;

    // Configuration: writes beyond the register list have no effect.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_count_reg <= COUNT_RESET;
            duration_ms_reg  <= DURATION_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MATRIX_COUNT: matrix_count_reg <= cfg_data[1:0];
                CFG_DURATION_MS:  duration_ms_reg  <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // Input register: capture the request.
    logic  in_valid_reg;
    pix_t  in_reg;
    pix_t  in_next;
    logic  in_en;
    logic  geom_in_ready;

    assign in_en    = !in_valid_reg || geom_in_ready;
    assign s_tready = in_en;

    assign in_next.elapsed_ms   = s_tdata[15:0];
    assign in_next.matrix_index = s_tdata[17:16];
    assign in_next.pixel_x      = s_tdata[20:18];
    assign in_next.pixel_y      = s_tdata[23:21];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_en)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_en && s_tvalid)
            in_reg <= in_next;
    end

    // Cell decode, group interval and column start.
    logic  geom_valid;
    logic  ramp_in_ready;
    geom_t geom;

    csf_geom u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .matrix_count (matrix_count_reg),
        .duration_ms  (duration_ms_reg),
        .in_valid     (in_valid_reg),
        .in_ready     (geom_in_ready),
        .in_pix       (in_reg),
        .out_valid    (geom_valid),
        .out_ready    (ramp_in_ready),
        .out_geom     (geom)
    );

    // Position on the triangle and the dividend t * 255.
    logic ramp_valid;
    logic div_in_ready;
    div_t ramp_div;

    csf_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_ready  (ramp_in_ready),
        .in_geom   (geom),
        .out_valid (ramp_valid),
        .out_ready (div_in_ready),
        .out_div   (ramp_div)
    );

    // Level = dividend / half fade, eight quotient bits.
    logic div_valid;
    logic out_en;
    div_t div_res;

    csf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ramp_valid),
        .in_ready  (div_in_ready),
        .in_div    (ramp_div),
        .out_valid (div_valid),
        .out_ready (out_en),
        .out_div   (div_res)
    );

    // Output register: pack the gray level as RGB565, force dark pixels to zero.
    logic               out_valid_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;

    assign out_en     = !out_valid_reg || m_tready;
    assign color_next = div_res.dark ? '0 : gray565(div_res.quo);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
            color_reg <= color_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = color_reg;

endmodule

>>> rtl/csf_checker.sv
// Port-level assertions for the checker sweep fade pixel core, with its bind.
`include "assert_macros.svh"

module csf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled color stays on the bus unchanged.
    `CSF_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `CSF_ASSERT_NXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))

    // Gray: red and blue carry the same five level bits.
    `CSF_ASSERT_IMP(a_gray_rb, clk, rst_n, m_tvalid, m_tdata[4:0] == m_tdata[15:11])

    // Gray: the upper five green bits match red.
    `CSF_ASSERT_IMP(a_gray_g, clk, rst_n, m_tvalid, m_tdata[10:6] == m_tdata[15:11])

    // With the output slot free the input side must be open.
    `CSF_ASSERT_IMP(a_ready_free, clk, rst_n, !m_tvalid && $past(!m_tvalid) && !s_tvalid,
                    s_tready)

endmodule

bind checker_sweep_fade_pixel_core csf_checker u_csf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
